// ===== rtl/nsrt_pkg.sv =====
`timescale 1ns / 1ps

package nsrt_pkg;

   localparam int ROOT_WIDTH      = 25;
   localparam int ITER_WIDTH      = 8;
   localparam int TOL_SHIFT_WIDTH = 6;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam logic [ROOT_WIDTH-1:0]      ROOT_MAX          = '1;
   localparam logic [TOL_SHIFT_WIDTH-1:0] TOL_SHIFT_RESET   = 6'd30;
   localparam logic [ITER_WIDTH-1:0]      MAX_ITER_RESET    = 8'd100;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOLERANCE_SHIFT = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_ITERATIONS  = 8'd1;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DIV    = 6'b000010,
      ST_MUL    = 6'b000100,
      ST_DIFF   = 6'b001000,
      ST_DECIDE = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

endpackage

// ===== rtl/newton_sqrt_relative_tolerance_unit.sv =====
`timescale 1ns / 1ps

// Newton-Raphson square root of an unsigned fixed-point radicand (FRAC_BITS
// fraction bits). The first guess is half the radicand; each step forms
// floor((g + floor(x * 2^FRAC_BITS / g)) / 2) and stops when
// |x * 2^FRAC_BITS - g^2| < (x * 2^FRAC_BITS) >> tolerance_shift or after
// max_iterations steps. One request is worked at a time and req_ready is low
// meanwhile. Each Newton step runs the restoring divider (one quotient bit
// a cycle), the shift-add squarer, and the tolerance check in ST_DIFF and
// ST_DECIDE. A request is loaded from idle, runs its steps, and hands its
// result to the output register, which may still hold the previous result
// while the next request runs. Radicands 0 and 1 (zero first guess), or a
// cap of zero, skip the Newton steps and return with converged low.
// Configuration writes are to take effect only while idle: the user must
// make them then, as the block itself does not enforce it.

module newton_sqrt_relative_tolerance_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [DATA_WIDTH-1:0]                req_radicand,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [nsrt_pkg::ROOT_WIDTH-1:0]      rsp_root,
   output logic [nsrt_pkg::ITER_WIDTH-1:0]      rsp_iterations_used,
   output logic                                 rsp_converged,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [nsrt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [nsrt_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int XW    = DATA_WIDTH + FRAC_BITS;
   localparam int AW    = 2 * DATA_WIDTH;
   localparam int CW    = (AW > XW) ? AW : XW;
   localparam int GW    = (DATA_WIDTH > nsrt_pkg::ROOT_WIDTH) ? DATA_WIDTH
                                                               : nsrt_pkg::ROOT_WIDTH;
   localparam int CNT_W = $clog2(XW + 1);
   localparam int IW    = nsrt_pkg::ITER_WIDTH;
   localparam int TW    = nsrt_pkg::TOL_SHIFT_WIDTH;

   nsrt_pkg::state_type state_ff, state_in;

   logic [TW-1:0]         tol_shift_ff, tol_shift_in;
   logic [IW-1:0]         max_iter_ff, max_iter_in;
   logic [DATA_WIDTH-1:0] x_ff, x_in;
   logic [DATA_WIDTH-1:0] g_ff, g_in;
   logic [XW-1:0]         tol_ff, tol_in;
   logic [IW-1:0]         n_ff, n_in;
   logic                  conv_ff, conv_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [XW-1:0]         dvd_ff, dvd_in;
   logic [DATA_WIDTH-1:0] mul_ff, mul_in;
   logic [AW-1:0]         acc_ff, acc_in;
   logic [CW-1:0]         diff_ff, diff_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [nsrt_pkg::ROOT_WIDTH-1:0] root_ff, root_in;
   logic [IW-1:0]         iter_ff, iter_in;
   logic                  rconv_ff, rconv_in;

   logic [XW-1:0]         xs_req;
   logic [XW-1:0]         xs_held;
   logic [DATA_WIDTH-1:0] g_req;
   logic [DATA_WIDTH:0]   trial;
   logic                  qbit;
   logic [XW-1:0]         q_full;
   logic [XW:0]           sum;
   logic [XW-1:0]         half;
   logic [DATA_WIDTH-1:0] g_next;
   logic [CW-1:0]         sq_ext;
   logic [CW-1:0]         xs_ext;
   logic [GW-1:0]         g_ext;
   logic                  load_rsp;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == nsrt_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_root  = root_ff;
   assign rsp_iterations_used = iter_ff;
   assign rsp_converged = rconv_ff;

   assign xs_req  = XW'(req_radicand) << FRAC_BITS;
   assign xs_held = XW'(x_ff) << FRAC_BITS;
   assign g_req   = req_radicand >> 1;

   assign trial  = {rem_ff, dvd_ff[XW-1]};
   assign qbit   = (trial >= {1'b0, g_ff});
   assign q_full = {dvd_ff[XW-2:0], qbit};
   assign sum    = (XW+1)'(g_ff) + (XW+1)'(q_full);
   assign half   = XW'(sum >> 1);
   assign g_next = (half > XW'({DATA_WIDTH{1'b1}})) ? {DATA_WIDTH{1'b1}}
                                                     : half[DATA_WIDTH-1:0];

   assign sq_ext = CW'(acc_ff);
   assign xs_ext = CW'(xs_held);
   assign g_ext  = GW'(g_ff);

   always_comb begin
      tol_shift_in = tol_shift_ff;
      max_iter_in  = max_iter_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            nsrt_pkg::CSR_TOLERANCE_SHIFT: tol_shift_in = csr_wdata[TW-1:0];
            nsrt_pkg::CSR_MAX_ITERATIONS:  max_iter_in  = csr_wdata[IW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      g_in     = g_ff;
      tol_in   = tol_ff;
      n_in     = n_ff;
      conv_in  = conv_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      mul_in   = mul_ff;
      acc_in   = acc_ff;
      diff_in  = diff_ff;
      load_rsp = 1'b0;
      case (state_ff)
         nsrt_pkg::ST_IDLE: begin
            if (req_valid) begin
               x_in    = req_radicand;
               g_in    = g_req;
               tol_in  = xs_req >> tol_shift_ff;
               n_in    = '0;
               conv_in = 1'b0;
               rem_in  = '0;
               dvd_in  = xs_req;
               cnt_in  = CNT_W'(XW - 1);
               if ((g_req == '0) || (max_iter_ff == '0)) begin
                  state_in = nsrt_pkg::ST_FINISH;
               end else begin
                  state_in = nsrt_pkg::ST_DIV;
               end
            end
         end
         nsrt_pkg::ST_DIV: begin
            rem_in = qbit ? DATA_WIDTH'(trial - {1'b0, g_ff}) : trial[DATA_WIDTH-1:0];
            dvd_in = q_full;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               g_in     = g_next;
               n_in     = n_ff + 1'b1;
               mul_in   = g_next;
               acc_in   = '0;
               cnt_in   = CNT_W'(DATA_WIDTH - 1);
               state_in = nsrt_pkg::ST_MUL;
            end
         end
         nsrt_pkg::ST_MUL: begin
            acc_in = (acc_ff << 1) + (mul_ff[DATA_WIDTH-1] ? AW'(g_ff) : '0);
            mul_in = mul_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = nsrt_pkg::ST_DIFF;
            end
         end
         nsrt_pkg::ST_DIFF: begin
            diff_in  = (sq_ext >= xs_ext) ? (sq_ext - xs_ext) : (xs_ext - sq_ext);
            state_in = nsrt_pkg::ST_DECIDE;
         end
         nsrt_pkg::ST_DECIDE: begin
            if (diff_ff < CW'(tol_ff)) begin
               conv_in  = 1'b1;
               state_in = nsrt_pkg::ST_FINISH;
            end else if ((n_ff == max_iter_ff) || (g_ff == '0)) begin
               state_in = nsrt_pkg::ST_FINISH;
            end else begin
               rem_in   = '0;
               dvd_in   = xs_held;
               cnt_in   = CNT_W'(XW - 1);
               state_in = nsrt_pkg::ST_DIV;
            end
         end
         nsrt_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = nsrt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nsrt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);
      root_in      = root_ff;
      iter_in      = iter_ff;
      rconv_in     = rconv_ff;
      if (load_rsp) begin
         root_in  = (g_ext > GW'(nsrt_pkg::ROOT_MAX)) ? nsrt_pkg::ROOT_MAX
                                                     : g_ext[nsrt_pkg::ROOT_WIDTH-1:0];
         iter_in  = n_ff;
         rconv_in = conv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nsrt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tol_shift_ff <= nsrt_pkg::TOL_SHIFT_RESET;
         max_iter_ff  <= nsrt_pkg::MAX_ITER_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tol_shift_ff <= tol_shift_in;
         max_iter_ff  <= max_iter_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      g_ff     <= g_in;
      tol_ff   <= tol_in;
      n_ff     <= n_in;
      conv_ff  <= conv_in;
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      mul_ff   <= mul_in;
      acc_ff   <= acc_in;
      diff_ff  <= diff_in;
      root_ff  <= root_in;
      iter_ff  <= iter_in;
      rconv_ff <= rconv_in;
   end

endmodule

// ===== verif/tb_newton_sqrt_relative_tolerance_unit.sv =====
`timescale 1ns / 1ps

module tb_newton_sqrt_relative_tolerance_unit;

   localparam int          DATA_W    = 32;
   localparam int          FRAC_BITS = 16;
   localparam logic [63:0] DATA_MASK = 64'hFFFF_FFFF;

   typedef struct packed {
      logic [nsrt_pkg::ROOT_WIDTH-1:0] root;
      logic [nsrt_pkg::ITER_WIDTH-1:0] iterations_used;
      logic                            converged;
   } root_result_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic [DATA_W-1:0]                    req_radicand = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic [nsrt_pkg::ROOT_WIDTH-1:0]      rsp_root;
   logic [nsrt_pkg::ITER_WIDTH-1:0]      rsp_iterations_used;
   logic                                 rsp_converged;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [nsrt_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [nsrt_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   logic [nsrt_pkg::TOL_SHIFT_WIDTH-1:0] tol_shift_cfg = nsrt_pkg::TOL_SHIFT_RESET;
   logic [nsrt_pkg::ITER_WIDTH-1:0]      iter_cap_cfg  = nsrt_pkg::MAX_ITER_RESET;

   logic [DATA_W-1:0] pending_radicands [$];
   root_result_type   expected_roots [$];
   int unsigned       queued_count   = 0;
   int unsigned       accepted_count = 0;
   int unsigned       mismatch_count = 0;
   int unsigned       send_idle_pct  = 38;
   int unsigned       recv_stall_pct = 73;
   logic              req_taken = 1'b0;

   logic [DATA_W-1:0] corner_radicands [$] = '{
      32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
      32'h0001_0000, 32'h0004_0000, 32'h0002_0000, 32'h0000_4000,
      32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
      32'h0000_FFFF, 32'h0100_0000, 32'h5555_5555, 32'hAAAA_AAAA
   };

   newton_sqrt_relative_tolerance_unit #(
      .DATA_WIDTH (DATA_W),
      .FRAC_BITS  (FRAC_BITS)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_radicand        (req_radicand),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_root            (rsp_root),
      .rsp_iterations_used (rsp_iterations_used),
      .rsp_converged       (rsp_converged),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #1_000_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Newton iteration on raw values, truncating, as the block does it
   function automatic root_result_type predict_root(input logic [DATA_W-1:0] x);
      logic [63:0]     scaled;
      logic [63:0]     guess;
      logic [63:0]     quot;
      logic [63:0]     nxt;
      logic [63:0]     sq;
      logic [63:0]     diff;
      logic [63:0]     tol;
      int unsigned     n;
      bit              met;
      root_result_type r;
      scaled = {32'd0, x} << FRAC_BITS;
      guess  = {33'd0, x[DATA_W-1:1]};
      tol    = scaled >> tol_shift_cfg;
      n      = 0;
      met    = 1'b0;
      if (guess != 0) begin
         while (n < iter_cap_cfg) begin
            quot = scaled / guess;
            nxt  = (guess >> 1) + (quot >> 1) + (guess & quot & 64'd1);
            if (nxt > DATA_MASK) begin
               nxt = DATA_MASK;
            end
            guess = nxt;
            n++;
            sq   = guess * guess;
            diff = (sq > scaled) ? sq - scaled : scaled - sq;
            if (diff < tol) begin
               met = 1'b1;
               break;
            end
            if (guess == 0) begin
               break;
            end
         end
      end
      r.root            = (guess > nsrt_pkg::ROOT_MAX) ? nsrt_pkg::ROOT_MAX
                                                       : guess[nsrt_pkg::ROOT_WIDTH-1:0];
      r.iterations_used = n[nsrt_pkg::ITER_WIDTH-1:0];
      r.converged       = met;
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] pick_radicand();
      logic [DATA_W-1:0] x;
      case ($urandom_range(9))
         5: begin
            x = $urandom_range(32'h0000_FFFF);
         end
         6: begin
            x = $urandom_range(3);
         end
         7: begin
            x = 32'h0000_FF80 + $urandom_range(255);
         end
         8: begin
            x = 32'd1 << $urandom_range(DATA_W - 1);
         end
         9: begin
            x = 32'hFFFF_FFFF - $urandom_range(15);
         end
         default: begin
            x = $urandom;
         end
      endcase
      return x;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_radicands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid    <= 1'b1;
            req_radicand <= pending_radicands.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      root_result_type exp_r;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_roots.push_back(predict_root(req_radicand));
            accepted_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_roots.size() == 0) begin
               $error("unexpected result: root %0h iterations %0d converged %0b",
                      rsp_root, rsp_iterations_used, rsp_converged);
               mismatch_count++;
            end else begin
               exp_r = expected_roots.pop_front();
               if (rsp_root !== exp_r.root) begin
                  $error("root: expected %0h, got %0h", exp_r.root, rsp_root);
                  mismatch_count++;
               end
               if (rsp_iterations_used !== exp_r.iterations_used) begin
                  $error("iterations_used: expected %0d, got %0d",
                         exp_r.iterations_used, rsp_iterations_used);
                  mismatch_count++;
               end
               if (rsp_converged !== exp_r.converged) begin
                  $error("converged: expected %0b, got %0b",
                         exp_r.converged, rsp_converged);
                  mismatch_count++;
               end
            end
         end
      end
   end

   task automatic queue_radicand(input logic [DATA_W-1:0] x);
      pending_radicands.push_back(x);
      queued_count++;
   endtask

   task automatic drain_requests();
      while (accepted_count != queued_count || expected_roots.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [nsrt_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [nsrt_pkg::CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      if (idx == nsrt_pkg::CSR_TOLERANCE_SHIFT) begin
         tol_shift_cfg = data[nsrt_pkg::TOL_SHIFT_WIDTH-1:0];
      end else if (idx == nsrt_pkg::CSR_MAX_ITERATIONS) begin
         iter_cap_cfg = data[nsrt_pkg::ITER_WIDTH-1:0];
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // both registers, then line up with the rising edge before queueing
   task automatic set_config(input int unsigned tol, input int unsigned cap);
      write_csr(nsrt_pkg::CSR_TOLERANCE_SHIFT, tol[nsrt_pkg::CSR_DATA_WIDTH-1:0]);
      write_csr(nsrt_pkg::CSR_MAX_ITERATIONS, cap[nsrt_pkg::CSR_DATA_WIDTH-1:0]);
      @(posedge clock);
   endtask

   initial begin
      int unsigned tol;
      int unsigned cap;
      int unsigned n_items;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner radicands at reset settings
      foreach (corner_radicands[i]) begin
         queue_radicand(corner_radicands[i]);
      end
      drain_requests();

      // zero cap returns the first guess untouched
      set_config(30, 0);
      queue_radicand(32'h0010_0000);
      queue_radicand(32'hFFFF_FFFF);
      queue_radicand(32'h0000_0001);
      drain_requests();

      set_config(0, 1);
      queue_radicand(32'hFFFF_FFFF);
      queue_radicand(32'h0009_0000);
      drain_requests();

      // tolerance never met: cap reached
      set_config(63, 255);
      queue_radicand(32'h0002_0000);
      queue_radicand(32'h0000_0003);
      drain_requests();

      for (int p = 0; p < 9; p++) begin
         case (p)
            0: begin
               tol = 0;
               cap = 255;
               n_items = 40;
            end
            1: begin
               tol = 63;
               cap = 3;
               n_items = 100;
            end
            2: begin
               tol = 30;
               cap = 100;
               n_items = 10;
            end
            default: begin
               tol = $urandom_range(63);
               cap = $urandom_range(1, 20);
               n_items = 110;
            end
         endcase
         if (p < 3) begin
            send_idle_pct  = 38;
            recv_stall_pct = 73;
         end else if (p < 6) begin
            send_idle_pct  = 73;
            recv_stall_pct = 38;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         set_config(tol, cap);
         repeat (n_items) queue_radicand(pick_radicand());
         drain_requests();
      end

      repeat (200) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
